### rtl/core/mfrd_pkg.sv
// ----------------------------------------------------------------------------
// mfrd_pkg
// shared types, constants and rate table helpers for the frame rate decimator
// ----------------------------------------------------------------------------
package mfrd_pkg;

  localparam int TS_W   = 32;   // timestamp width
  localparam int RATE_W = 16;   // internal rate width
  localparam int CFG_W  = 8;    // requested rate register width
  localparam int DIV_W  = 32;   // serial divider width

  localparam logic [TS_W-1:0]   WINDOW_MS   = 32'd10000;
  localparam logic [RATE_W-1:0] COUNT_LIMIT = 16'd30;
  localparam logic [RATE_W-1:0] RESET_RATE  = 16'd30;
  localparam logic [1:0]        MAX_ADJ     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAS,
    ST_RATIO,
    ST_MOD,
    ST_EMIT
  } mfrd_state_t;

  // working rate snapped onto the supported steps
  function automatic logic [RATE_W-1:0] table_rate(input logic [RATE_W-1:0] r);
    logic [RATE_W-1:0] w;
    if (r <= 16'd1) w = 16'd1;
    else if (r <= 16'd5) w = 16'd5;
    else if (r <= 16'd10) w = 16'd10;
    else if (r <= 16'd15) w = 16'd15;
    else w = r;
    return w;
  endfunction

  // announced rate when every frame passes
  function automatic logic [RATE_W-1:0] ladder_rate(input logic [RATE_W-1:0] m);
    logic [RATE_W-1:0] a;
    if (m > 16'd30) a = m;
    else if (m > 16'd25) a = 16'd30;
    else if (m > 16'd20) a = 16'd25;
    else if (m > 16'd15) a = 16'd20;
    else if (m > 16'd10) a = 16'd15;
    else if (m > 16'd5) a = 16'd10;
    else if (m > 16'd1) a = 16'd5;
    else a = 16'd1;
    return a;
  endfunction

endpackage

### rtl/core/measured_frame_rate_decimator.sv
// ----------------------------------------------------------------------------
// measured_frame_rate_decimator
// measures the source frame rate and keeps every n-th frame to match it
// ----------------------------------------------------------------------------
// Each input word is one frame arrival with its millisecond timestamp; each
// output word says whether that frame is kept, the rate announced with kept
// frames (zero for dropped ones) and the last measured source rate. One frame
// is in work at a time. An ordinary frame runs the 32-step bit-serial modulo
// of the skip position and then has its output word loaded into the output
// register once that register is free. A frame that closes a measurement
// window (at most twice after reset) first runs the serial division
// count*1000/duration, and then derives a skip ratio by a further division
// when one is needed. The single shared serial divider performs all of these
// divisions, and the input takes no new frame before the last one is through.
// The output register frees the input side as soon as a result is parked
// there. Writing requested_rate reloads the working rate; the write port is
// open only while no frame is in work.
// ----------------------------------------------------------------------------
module measured_frame_rate_decimator
  import mfrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // frame arrivals
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [TS_W-1:0]  in_tdata,    // [31:0] timestamp_ms
  // per-frame decisions
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,   // [15:0] reported_rate, [31:16] source_rate
  output logic             out_tuser,   // [0] pass_frame
  // requested rate register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  mfrd_state_t state_r, state_nxt;

  // rate control state
  logic [RATE_W-1:0] working_rate_r, working_rate_nxt;
  logic [RATE_W-1:0] measured_rate_r, measured_rate_nxt;
  logic [RATE_W-1:0] frame_tally_r, frame_tally_nxt;
  logic [TS_W-1:0]   window_start_r, window_start_nxt;
  logic [1:0]        adjust_tally_r, adjust_tally_nxt;
  logic [RATE_W-1:0] skip_factor_r, skip_factor_nxt;
  logic [TS_W-1:0]   skip_position_r, skip_position_nxt;
  logic [RATE_W-1:0] announced_rate_r, announced_rate_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;       // timestamp of the frame in work
  logic              pass_r, pass_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_pass_r, out_pass_nxt;
  logic [RATE_W-1:0] out_rep_r, out_rep_nxt;
  logic [RATE_W-1:0] out_src_r, out_src_nxt;

  // shared serial divider
  logic              div_start;
  logic [DIV_W-1:0]  div_dend;
  logic [DIV_W-1:0]  div_dsor;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [DIV_W-1:0]  div_rem;

  // helpers
  logic              in_fire;
  logic [TS_W-1:0]   ws_eff;
  logic [TS_W-1:0]   dur;
  logic [RATE_W-1:0] tally_inc;
  logic [25:0]       tally_x1000;
  logic [RATE_W-1:0] m_new;
  logic [RATE_W-1:0] w_new;
  logic [RATE_W-1:0] d_eff;
  logic [RATE_W-1:0] skip_eff;

  mfrd_div #(.W(DIV_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dend),
    .divisor   (div_dsor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    // window opens on the first nonzero timestamp
    ws_eff      = (window_start_r == '0) ? in_tdata : window_start_r;
    dur         = in_tdata - ws_eff;
    tally_inc   = frame_tally_r + 16'd1;
    // count * 1000 as shifts and subtracts
    tally_x1000 = {tally_inc, 10'b0} - {6'b0, tally_inc, 4'b0}
                  - {7'b0, tally_inc, 3'b0};
    m_new       = div_quo[RATE_W-1:0];
    w_new       = table_rate(working_rate_r);
    d_eff       = (working_rate_r == '0) ? 16'd1 : working_rate_r;
    skip_eff    = (skip_factor_r == '0) ? 16'd1 : skip_factor_r;

    state_nxt          = state_r;
    working_rate_nxt   = working_rate_r;
    measured_rate_nxt  = measured_rate_r;
    frame_tally_nxt    = frame_tally_r;
    window_start_nxt   = window_start_r;
    adjust_tally_nxt   = adjust_tally_r;
    skip_factor_nxt    = skip_factor_r;
    skip_position_nxt  = skip_position_r;
    announced_rate_nxt = announced_rate_r;
    ts_nxt             = ts_r;
    pass_nxt           = pass_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    out_pass_nxt       = out_pass_r;
    out_rep_nxt        = out_rep_r;
    out_src_nxt        = out_src_r;
    div_start          = 1'b0;
    div_dend           = DIV_W'(skip_position_r);
    div_dsor           = {{(DIV_W-RATE_W){1'b0}}, skip_eff};

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          working_rate_nxt = {{(RATE_W-CFG_W){1'b0}}, cfg_data};
        end else if (in_fire) begin
          ts_nxt           = in_tdata;
          window_start_nxt = ws_eff;
          div_start        = 1'b1;
          state_nxt        = ST_MOD;
          if (working_rate_r <= COUNT_LIMIT) begin
            frame_tally_nxt = tally_inc;
            if (dur >= WINDOW_MS && adjust_tally_r < MAX_ADJ) begin
              // close the window: rate = count*1000/duration
              div_dend  = {{(DIV_W-26){1'b0}}, tally_x1000};
              div_dsor  = dur;
              state_nxt = ST_MEAS;
            end
          end
        end
      end
      ST_MEAS: begin
        if (div_done) begin
          measured_rate_nxt = m_new;
          frame_tally_nxt   = '0;
          window_start_nxt  = ts_r;
          adjust_tally_nxt  = adjust_tally_r + 2'd1;
          working_rate_nxt  = w_new;
          div_start         = 1'b1;
          if (w_new >= m_new) begin
            skip_factor_nxt    = 16'd1;
            announced_rate_nxt = ladder_rate(m_new);
            div_dsor           = {{(DIV_W-1){1'b0}}, 1'b1};
            state_nxt          = ST_MOD;
          end else begin
            // rounded ratio (2m + r) / (2r), old working rate
            announced_rate_nxt = w_new;
            div_dend  = {{(DIV_W-RATE_W-2){1'b0}},
                         {1'b0, m_new, 1'b0} + {2'b0, d_eff}};
            div_dsor  = {{(DIV_W-RATE_W-1){1'b0}}, d_eff, 1'b0};
            state_nxt = ST_RATIO;
          end
        end
      end
      ST_RATIO: begin
        if (div_done) begin
          skip_factor_nxt = div_quo[RATE_W-1:0];
          div_start       = 1'b1;
          div_dsor        = {{(DIV_W-RATE_W){1'b0}},
                             (div_quo[RATE_W-1:0] == '0) ? 16'd1 : div_quo[RATE_W-1:0]};
          state_nxt       = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          // keep the frame when position mod skip is zero
          pass_nxt          = (div_rem == '0);
          skip_position_nxt = skip_position_r + 32'd1;
          state_nxt         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pass_nxt  = pass_r;
          out_rep_nxt   = pass_r ? announced_rate_r : '0;
          out_src_nxt   = measured_rate_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      working_rate_r   <= RESET_RATE;
      measured_rate_r  <= RESET_RATE;
      frame_tally_r    <= '0;
      window_start_r   <= '0;
      adjust_tally_r   <= '0;
      skip_factor_r    <= 16'd1;
      skip_position_r  <= '0;
      announced_rate_r <= RESET_RATE;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      working_rate_r   <= working_rate_nxt;
      measured_rate_r  <= measured_rate_nxt;
      frame_tally_r    <= frame_tally_nxt;
      window_start_r   <= window_start_nxt;
      adjust_tally_r   <= adjust_tally_nxt;
      skip_factor_r    <= skip_factor_nxt;
      skip_position_r  <= skip_position_nxt;
      announced_rate_r <= announced_rate_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ts_r       <= ts_nxt;
    pass_r     <= pass_nxt;
    out_pass_r <= out_pass_nxt;
    out_rep_r  <= out_rep_nxt;
    out_src_r  <= out_src_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_src_r, out_rep_r};
  assign out_tuser  = out_pass_r;

  // at most two measurements ever happen
  a_adjust_bound: assert property (@(posedge clk) disable iff (!rst_n)
    adjust_tally_r <= MAX_ADJ)
    else $error("adjust tally beyond limit");

  // the divider is never restarted while it still iterates
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a dropped frame announces no rate
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[15:0] == '0))
    else $error("dropped frame carries a rate");

  // a derived skip ratio is never zero
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RATIO && div_done) |=> (skip_factor_r != '0))
    else $error("skip ratio came out zero");

endmodule

### rtl/core/mfrd_div.sv
// ----------------------------------------------------------------------------
// mfrd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mfrd_div
  import mfrd_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,    // nonzero
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsor_r, dsor_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, dsor_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract of the next partial remainder
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
